FILE: design/positional_insert_list_unit_assert.svh
// assertion macros for the positional insert list unit
// needs a clk and an active-low rst_n in the scope of each use
`ifndef POSITIONAL_INSERT_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_INSERT_LIST_UNIT_ASSERT_SVH

// same-cycle implication
`define PLU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional insert list check failed");

// next-cycle implication
`define PLU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional insert list check failed");

`endif

FILE: design/plu_pkg.sv
// shared types for the positional insert list unit
// no dependencies
package plu_pkg;

  // input command codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DUMP   = 1'b1
  } plu_op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } plu_stat_t;

  localparam int ResultLimit = 32;

  // controller to datapath
  typedef struct packed {
    logic      insert;      // shift in the value and emit an ok result
    logic      reject;      // emit a single result with rej_status
    plu_stat_t rej_status;
    logic      dump_start;  // clear the dump step counter
    logic      dump_step;   // rotate the list by one entry
    logic      dump_emit;   // also emit the head entry as a result
  } plu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_bad;
    logic full;
    logic empty;
    logic out_free;
    logic dump_final;
    logic dump_emits;
  } plu_sts_t;

endpackage

FILE: design/plu_ctrl.sv
// controller for the positional insert list unit
// depends on plu_pkg
module plu_ctrl import plu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_stall,
  input  plu_sts_t sts,
  output plu_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = !((state_r == S_IDLE) && sts.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.rej_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (plu_op_t'(in_cmd) == OP_INSERT) begin
            if (sts.pos_bad) begin
              cmd.reject     = 1'b1;
              cmd.rej_status = ST_BAD_POS;
            end else if (sts.full) begin
              cmd.reject     = 1'b1;
              cmd.rej_status = ST_FULL;
            end else begin
              cmd.insert = 1'b1;
            end
          end else if (sts.empty) begin
            cmd.reject     = 1'b1;
            cmd.rej_status = ST_EMPTY;
          end else begin
            cmd.dump_start = 1'b1;
            state_nxt      = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        // entries past the result limit are rotated without being emitted
        if (!sts.dump_emits || sts.out_free) begin
          cmd.dump_step = 1'b1;
          cmd.dump_emit = sts.dump_emits;
          if (sts.dump_final) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/plu_dp.sv
// datapath for the positional insert list unit: list cells, tallies, result register
// depends on plu_pkg
module plu_dp import plu_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [5:0]         in_position,
  input  logic signed [31:0] in_value,
  input  plu_cmd_t           cmd,
  output plu_sts_t           sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [4:0]         out_index,
  output logic signed [31:0] out_element,
  output logic               out_last,
  output logic [5:0]         out_entry_count,
  output logic [5:0]         out_positive_count,
  output logic [5:0]         out_negative_count
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > 6) ? CW : 6) + 1;

  logic signed [31:0] cells_r   [DEPTH];
  logic signed [31:0] cells_nxt [DEPTH];
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      nonneg_r, nonneg_nxt;
  logic [CW-1:0]      neg_r, neg_nxt;
  logic [CW-1:0]      step_r, step_nxt;

  logic [CMPW-1:0]    pos_ext, slot_ext, count_ext, cnt_m1, step_ext, lim_ext;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r;
  logic [4:0]         out_index_r;
  logic signed [31:0] out_element_r;
  logic               out_last_r;
  logic [5:0]         out_entry_r, out_pos_r, out_neg_r;
  logic               load;

  assign pos_ext   = CMPW'(in_position);
  assign slot_ext  = pos_ext - CMPW'(1);
  assign count_ext = CMPW'(count_r);
  assign cnt_m1    = count_ext - CMPW'(1);
  assign step_ext  = CMPW'(step_r);
  assign lim_ext   = (count_ext > CMPW'(ResultLimit)) ? CMPW'(ResultLimit) : count_ext;

  assign sts.pos_bad    = (in_position == 6'd0) || (pos_ext > count_ext + CMPW'(1));
  assign sts.full       = (count_r == CW'(DEPTH));
  assign sts.empty      = (count_r == '0);
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.dump_final = (step_ext == cnt_m1);
  assign sts.dump_emits = (step_ext < CMPW'(ResultLimit));

  // per-cell next value: insert shifts later entries back, dump rotates to the front
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic [CMPW-1:0] Kk = CMPW'(k);
    always_comb begin
      cells_nxt[k] = cells_r[k];
      if (cmd.insert) begin
        if (Kk == slot_ext) begin
          cells_nxt[k] = in_value;
        end
        if (k > 0) begin
          if ((Kk > slot_ext) && (Kk <= count_ext)) begin
            cells_nxt[k] = cells_r[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (cmd.dump_step) begin
        if (Kk == cnt_m1) begin
          cells_nxt[k] = cells_r[0];
        end else if (Kk < cnt_m1) begin
          cells_nxt[k] = cells_r[(k < DEPTH - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    nonneg_nxt = nonneg_r;
    neg_nxt    = neg_r;
    step_nxt   = step_r;
    if (cmd.insert) begin
      count_nxt = count_r + CW'(1);
      if (in_value[31]) begin
        neg_nxt = neg_r + CW'(1);
      end else begin
        nonneg_nxt = nonneg_r + CW'(1);
      end
    end
    if (cmd.dump_start) begin
      step_nxt = '0;
    end else if (cmd.dump_step) begin
      step_nxt = step_r + CW'(1);
    end
  end

  assign load          = cmd.insert || cmd.reject || cmd.dump_emit;
  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      nonneg_r    <= '0;
      neg_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      nonneg_r    <= nonneg_nxt;
      neg_r       <= neg_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
    if (load) begin
      out_entry_r <= 6'(count_nxt);
      out_pos_r   <= 6'(nonneg_nxt);
      out_neg_r   <= 6'(neg_nxt);
      if (cmd.insert) begin
        out_status_r  <= ST_OK;
        out_index_r   <= 5'(slot_ext);
        out_element_r <= in_value;
        out_last_r    <= 1'b1;
      end else if (cmd.reject) begin
        out_status_r  <= cmd.rej_status;
        out_index_r   <= '0;
        out_element_r <= '0;
        out_last_r    <= 1'b1;
      end else begin
        out_status_r  <= ST_OK;
        out_index_r   <= 5'(step_r);
        out_element_r <= cells_r[0];
        out_last_r    <= (step_ext == lim_ext - CMPW'(1));
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_index          = out_index_r;
  assign out_element        = out_element_r;
  assign out_last           = out_last_r;
  assign out_entry_count    = out_entry_r;
  assign out_positive_count = out_pos_r;
  assign out_negative_count = out_neg_r;

endmodule

FILE: design/positional_insert_list_unit.sv
// top level of the positional insert list unit
// depends on plu_pkg, plu_ctrl, plu_dp and positional_insert_list_unit_assert.svh
//
// bounded ordered list of up to DEPTH signed 32-bit values held in a row of
// registers. an insert transaction (cmd 0) names a 1-based position: the value
// goes in at that slot and every later entry moves back one place.
// it yields one result: ok with the slot and value, bad position when
// the position is zero or beyond count+1, or list full. a dump transaction
// (cmd 1) yields one result per stored entry in order with last set on the
// final one (at most 32 results), or one list-empty result. every result
// carries the entry count and the non-negative and negative tallies as they
// stand after the transaction; these are kept as running counters.
// timing: an insert or any rejected transaction leaves the controller idle, and
// the next input can be taken in the following cycle if the output register
// is free or its result is being taken. a dump first clears the step counter,
// then reads the list at its head and rotates it by one entry per cycle;
// input is stalled until the rotation is complete and output stalls stretch it.
// there is no clearing pass: entries are only read below the entry count.
`include "positional_insert_list_unit_assert.svh"

module positional_insert_list_unit import plu_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [5:0]         in_position,
  input  logic signed [31:0] in_value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [4:0]         out_index,
  output logic signed [31:0] out_element,
  output logic               out_last,
  output logic [5:0]         out_entry_count,
  output logic [5:0]         out_positive_count,
  output logic [5:0]         out_negative_count
);

  plu_cmd_t cmd;  // per-cycle commands from the controller
  plu_sts_t sts;  // list and output register status

  // sequencer: idle or walking the list for a dump
  plu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // list cells, running tallies and the result register
  plu_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_position        (in_position),
    .in_value           (in_value),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_index          (out_index),
    .out_element        (out_element),
    .out_last           (out_last),
    .out_entry_count    (out_entry_count),
    .out_positive_count (out_positive_count),
    .out_negative_count (out_negative_count)
  );

  // tallies always add up to the entry count (all modulo the field width)
  `PLU_ASSERT_IMP(a_tally_sum, out_valid, 6'(out_positive_count + out_negative_count) == out_entry_count)
  // any non-ok status is a single-result transaction
  `PLU_ASSERT_IMP(a_err_last, out_valid && (out_status != ST_OK), out_last)
  // no input is taken while the list is being rotated
  `PLU_ASSERT_IMP(a_dump_stall, cmd.dump_step, in_stall)
  // at most one datapath action per cycle
  `PLU_ASSERT_IMP(a_cmd_excl, 1'b1, $onehot0({cmd.insert, cmd.reject, cmd.dump_start, cmd.dump_step}))

endmodule

FILE: tb/tb_positional_insert_list_unit.sv
// self-checking testbench for positional_insert_list_unit: directed and random
// insert and dump transactions, checked field by field against a list model held here
// depends on plu_pkg and the positional_insert_list_unit rtl
module tb_positional_insert_list_unit;
  import plu_pkg::*;

  localparam int DEPTH        = 32;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int LONG_HOLD    = 250;  // receiver hold-off, long enough to back the unit up
  localparam int DRAIN_CYCLES = 40;   // settle time once nothing is outstanding
  localparam int PHASE_ITEMS  = 95;
  localparam int HOLD_ITEMS   = 20;
  localparam int MAX_PRINTS   = 40;
  localparam longint RUN_LIMIT = 64'd3200000;  // time limit, far beyond the slowest run

  // one input transaction as queued for the driver
  typedef struct packed {
    logic               op;
    logic [5:0]         position;
    logic signed [31:0] value;
  } list_req_t;

  // one expected result transaction
  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         index;
    logic signed [31:0] element;
    logic               last;
    logic [5:0]         entry_count;
    logic [5:0]         positive_count;
    logic [5:0]         negative_count;
  } list_result_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = 1'b0;
  logic [5:0]         in_position = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [4:0]         out_index;
  logic signed [31:0] out_element;
  logic               out_last;
  logic [5:0]         out_entry_count;
  logic [5:0]         out_positive_count;
  logic [5:0]         out_negative_count;

  positional_insert_list_unit #(.DEPTH(DEPTH)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_index          (out_index),
    .out_element        (out_element),
    .out_last           (out_last),
    .out_entry_count    (out_entry_count),
    .out_positive_count (out_positive_count),
    .out_negative_count (out_negative_count)
  );

  // stimulus side bookkeeping
  list_req_t    pending_reqs[$];      // transactions waiting for the driver
  list_req_t    next_req;
  int           gen_len = 0;          // list length as the generator sees it
  int           sent_cnt = 0;         // transactions put on the input port
  int           accepted_cnt = 0;     // transactions taken by the unit
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  logic         hold_req = 1'b0;
  int           hold_left = 0;

  // list model and the results it predicts
  logic signed [31:0] model_list [DEPTH];
  int           model_len = 0;
  int           model_nonneg = 0;
  int           model_neg = 0;
  list_result_t expected_results[$];
  list_req_t    sampled_req;
  list_result_t want;
  int           result_cnt = 0;
  int           error_count = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // hard stop in case the unit hangs or drops results
  initial begin
    #(RUN_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("result %0d: %s got %0h expected %0h", result_cnt, what, got, exp_val);
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  // apply one accepted transaction to the list model and queue what it yields
  task automatic predict_list_op(input list_req_t req);
    list_result_t res;
    int           slot;
    int           dump_len;
    int           k;
    res = '0;
    res.last = 1'b1;
    dump_len = 0;
    if (req.op == OP_INSERT) begin
      slot = int'(req.position) - 1;
      // a bad position wins over a full list
      if (req.position == 0 || int'(req.position) > model_len + 1) begin
        res.status = ST_BAD_POS;
      end else if (model_len >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (k = model_len; k > slot; k--) model_list[k] = model_list[k - 1];
        model_list[slot] = req.value;
        model_len++;
        if (req.value < 0) model_neg++;
        else model_nonneg++;
        res.status  = ST_OK;
        res.index   = slot[4:0];
        res.element = req.value;
      end
    end else if (model_len == 0) begin
      res.status = ST_EMPTY;
    end else begin
      dump_len = (model_len > ResultLimit) ? ResultLimit : model_len;
    end
    // tallies as they stand after the transaction
    res.entry_count    = model_len[5:0];
    res.positive_count = model_nonneg[5:0];
    res.negative_count = model_neg[5:0];
    if (dump_len == 0) expected_results.push_back(res);
    for (k = 0; k < dump_len; k++) begin
      res.status  = ST_OK;
      res.index   = k[4:0];
      res.element = model_list[k];
      res.last    = (k == dump_len - 1);
      expected_results.push_back(res);
    end
  endtask

  // values lean towards the sign boundary now and then
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(7) != 0) return $urandom;
    case ($urandom_range(3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic queue_insert(input int pos, input logic signed [31:0] value);
    list_req_t req;
    req.op       = OP_INSERT;
    req.position = pos[5:0];
    req.value    = value;
    if (pos >= 1 && pos <= gen_len + 1 && gen_len < DEPTH) gen_len++;
    pending_reqs.push_back(req);
  endtask

  task automatic queue_dump();
    list_req_t req;
    req.op       = OP_DUMP;
    req.position = 6'($urandom_range(63));  // ignored by the unit
    req.value    = $urandom;
    pending_reqs.push_back(req);
  endtask

  // mostly rejected inserts and dumps, with good inserts rare enough that
  // the list takes most of the run to fill
  task automatic queue_random_item();
    int roll;
    int pos;
    roll = $urandom_range(99);
    if (roll < 10) begin
      case ($urandom_range(3))
        0:       pos = 1;
        1:       pos = gen_len + 1;
        default: pos = $urandom_range(gen_len + 1, 1);
      endcase
      queue_insert(pos, pick_value());
    end else if (roll < 40) begin
      queue_dump();
    end else if ($urandom_range(7) == 0) begin
      queue_insert(0, pick_value());
    end else begin
      queue_insert($urandom_range(63, gen_len + 2), pick_value());
    end
  endtask

  task automatic wait_for_driver();
    while (pending_reqs.size() != 0) @(posedge clk);
  endtask

  task automatic wait_until_drained();
    while (pending_reqs.size() != 0 || accepted_cnt != sent_cnt ||
           expected_results.size() != 0) @(posedge clk);
  endtask

  // driver: a transaction stays on the port until the unit takes it
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (accepted_cnt == sent_cnt) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        in_cmd      <= next_req.op;
        in_position <= next_req.position;
        in_value    <= next_req.value;
        in_valid    <= 1'b1;
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: input side first so a same-edge result still finds its expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sampled_req.op       = in_cmd;
        sampled_req.position = in_position;
        sampled_req.value    = in_value;
        predict_list_op(sampled_req);
        accepted_cnt++;
      end
      if (out_valid && !out_stall) begin
        result_cnt++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, element", 64'(out_element), 64'd0);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(out_status), 64'(want.status));
          check_field("index", 64'(out_index), 64'(want.index));
          check_field("element", 64'(out_element), 64'(want.element));
          check_field("last", 64'(out_last), 64'(want.last));
          check_field("entry_count", 64'(out_entry_count), 64'(want.entry_count));
          check_field("positive_count", 64'(out_positive_count),
                      64'(want.positive_count));
          check_field("negative_count", 64'(out_negative_count),
                      64'(want.negative_count));
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty dump, rejected positions at both extremes, front,
    // append and middle inserts across the sign boundary, then a dump
    queue_dump();
    queue_insert(0, 32'sd5);
    queue_insert(2, 32'sd7);
    queue_insert(63, -32'sd1);
    queue_insert(1, 32'sh8000_0000);
    queue_insert(2, 32'sh7fff_ffff);
    queue_insert(1, 32'sd0);
    queue_insert(2, -32'sd1);
    queue_insert(5, 32'sd1);
    queue_insert(7, 32'sd9);
    queue_dump();
    // sender holds back until every result of the directed part is in
    wait_until_drained();

    // no idling; a long receiver hold-off early on backs up the unit
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (HOLD_ITEMS) queue_random_item();
    hold_req = 1'b1;
    while (hold_left == 0) @(posedge clk);
    hold_req = 1'b0;
    repeat (PHASE_ITEMS - HOLD_ITEMS) queue_random_item();
    wait_for_driver();

    // sender idle about half the time
    send_idle_pct = 51;
    repeat (PHASE_ITEMS) queue_random_item();
    wait_for_driver();

    // receiver stalling about half the time
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    repeat (PHASE_ITEMS) queue_random_item();
    wait_for_driver();

    // both sides idling
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    repeat (PHASE_ITEMS) queue_random_item();
    // top the list up, then hit the full list and a full-length dump
    while (gen_len < DEPTH) queue_insert($urandom_range(gen_len + 1, 1), pick_value());
    queue_insert(DEPTH + 1, pick_value());
    queue_insert(1, pick_value());
    queue_insert(DEPTH + 2, pick_value());
    queue_insert(63, pick_value());
    queue_dump();

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: positional_insert_list_unit.f
+incdir+design
design/plu_pkg.sv
design/plu_ctrl.sv
design/plu_dp.sv
design/positional_insert_list_unit.sv
tb/tb_positional_insert_list_unit.sv
